// ===== rtl/cbrb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrb_pkg
// Shared types, codes and defaults for the chunked byte ring buffer.
// ----------------------------------------------------------------------------
package cbrb_pkg;

    // Default sizes
    localparam int CAPACITY_DEF = 4096;
    localparam int MAX_POP_DEF  = 64;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int LEN_W    = 13;
    localparam int DATA_W   = 8;
    localparam int LIMIT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 13;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    // Operation codes on the input channel
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd1;
    localparam logic [OP_W-1:0] OP_POP     = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BUSY     = 3'd3,
        ST_NORES    = 3'd4
    } status_t;

    // Item class decided by the front
    typedef enum logic [1:0] {
        K_RESERVE,
        K_PUSH,
        K_POP,
        K_NOP
    } item_kind_t;

    // Classified item held in the queue
    typedef struct packed {
        item_kind_t           kind;
        logic [LEN_W-1:0]     len;
        logic [DATA_W-1:0]    data;
        logic [LIMIT_W-1:0]   limit;
    } item_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP_RD,
        BK_POP_OUT
    } back_state_t;

endpackage

// ===== rtl/cbrb_ram.sv =====
// ----------------------------------------------------------------------------
// cbrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cbrb_front.sv =====
// ----------------------------------------------------------------------------
// cbrb_front
// Accepts input transactions, classifies them and clamps the pop limit,
// then holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module cbrb_front #(
    parameter int MAX_POP = cbrb_pkg::MAX_POP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cbrb_pkg::OP_W-1:0]     operation,
    input  logic [cbrb_pkg::LEN_W-1:0]    chunk_length,
    input  logic [cbrb_pkg::DATA_W-1:0]   data_byte,
    input  logic [cbrb_pkg::LIMIT_W-1:0]  pop_limit,
    output logic                          q_valid,
    output cbrb_pkg::item_t               q_item,
    input  logic                          q_take
);

    import cbrb_pkg::*;

    localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    item_t            entry_reg [QDEPTH];
    logic [QPW-1:0]   wp_reg, wp_next;
    logic [QPW-1:0]   rp_reg, rp_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    item_t            cls_item;
    logic             push_q;
    logic             pop_q;

    // Classify the incoming transaction
    always_comb
    begin
        cls_item.len  = chunk_length;
        cls_item.data = data_byte;
        case (operation)
            OP_RESERVE: cls_item.kind = K_RESERVE;
            OP_PUSH:    cls_item.kind = K_PUSH;
            OP_POP:     cls_item.kind = K_POP;
            default:    cls_item.kind = K_NOP;
        endcase
        // Clamp the limit to one .. MAX_POP
        if (pop_limit == '0)
        begin
            cls_item.limit = LIMIT_W'(1);
        end
        else if (pop_limit > LIMIT_W'(MAX_POP))
        begin
            cls_item.limit = LIMIT_W'(MAX_POP);
        end
        else
        begin
            cls_item.limit = pop_limit;
        end
    end

    assign in_ready = (cnt_reg != QCW'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = entry_reg[rp_reg];
    assign push_q   = in_valid && in_ready;
    assign pop_q    = q_take && q_valid;

    // Advance queue pointers and count
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push_q)
        begin
            wp_next = (wp_reg == QPW'(QDEPTH - 1)) ? '0 : wp_reg + QPW'(1);
        end
        if (pop_q)
        begin
            rp_next = (rp_reg == QPW'(QDEPTH - 1)) ? '0 : rp_reg + QPW'(1);
        end
        if (push_q && !pop_q)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (pop_q && !push_q)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            entry_reg[wp_reg] <= cls_item;
        end
    end

endmodule

// ===== rtl/cbrb_back.sv =====
// ----------------------------------------------------------------------------
// cbrb_back
// Carries out queued items against the byte store and the ring indices,
// and drives the result channel through an output register.
// ----------------------------------------------------------------------------
module cbrb_back #(
    parameter int CAPACITY = cbrb_pkg::CAPACITY_DEF,
    parameter int MAX_POP  = cbrb_pkg::MAX_POP_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  cbrb_pkg::item_t                q_item,
    output logic                           q_take,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cbrb_pkg::STATUS_W-1:0]  status,
    output logic [cbrb_pkg::DATA_W-1:0]    popped_byte,
    output logic                           last,
    output logic [cbrb_pkg::FREE_W-1:0]    free_space
);

    import cbrb_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REM_W = $clog2(MAX_POP + 1);
    localparam int FW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int MW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   wi_reg, wi_next;
    logic [IDX_W-1:0]   ri_reg, ri_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   pend_reg, pend_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    logic               ov_reg;
    status_t            ost_reg;
    logic [DATA_W-1:0]  obyte_reg;
    logic               olast_reg;
    logic [FREE_W-1:0]  ofree_reg;

    logic               out_free;
    logic               load;
    status_t            ld_st;
    logic [DATA_W-1:0]  ld_byte;
    logic               ld_last;
    logic [FREE_W-1:0]  ld_free;
    logic [CNT_W-1:0]   free_cur;
    logic [CNT_W-1:0]   free_nxt;
    logic [FW-1:0]      free_ext;
    logic [MW-1:0]      n_pop;

    logic               ram_we;
    logic               ram_re;
    logic [DATA_W-1:0]  ram_rdata;

    assign out_free = !ov_reg || out_ready;
    assign free_cur = CNT_W'(CAPACITY) - used_reg;
    assign n_pop    = (MW'(q_item.limit) < MW'(used_reg)) ? MW'(q_item.limit)
                                                          : MW'(used_reg);

    // Byte store
    cbrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata (q_item.data),
        .re    (ram_re),
        .raddr (ri_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_item.kind == K_POP && used_reg != '0)
                begin
                    state_next = BK_POP_RD;
                end
            end
            BK_POP_RD:
            begin
                state_next = BK_POP_OUT;
            end
            BK_POP_OUT:
            begin
                if (out_free)
                begin
                    state_next = (rem_reg == REM_W'(1)) ? BK_IDLE : BK_POP_RD;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        wi_next   = wi_reg;
        ri_next   = ri_reg;
        used_next = used_reg;
        pend_next = pend_reg;
        rem_next  = rem_reg;
        q_take    = 1'b0;
        load      = 1'b0;
        ld_st     = ST_OK;
        ld_byte   = '0;
        ld_last   = 1'b1;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        K_RESERVE:
                        begin
                            if (out_free)
                            begin
                                q_take = 1'b1;
                                load   = 1'b1;
                                if (pend_reg != '0)
                                begin
                                    ld_st = ST_BUSY;
                                end
                                else if (FW'(q_item.len) > FW'(free_cur))
                                begin
                                    ld_st = ST_OVERFLOW;
                                end
                                else
                                begin
                                    pend_next = CNT_W'(q_item.len);
                                end
                            end
                        end
                        K_PUSH:
                        begin
                            if (out_free)
                            begin
                                q_take = 1'b1;
                                load   = 1'b1;
                                if (pend_reg == '0)
                                begin
                                    ld_st = ST_NORES;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    wi_next   = (wi_reg == IDX_W'(CAPACITY - 1)) ?
                                                '0 : wi_reg + IDX_W'(1);
                                    pend_next = pend_reg - CNT_W'(1);
                                    used_next = used_reg + CNT_W'(1);
                                end
                            end
                        end
                        K_POP:
                        begin
                            if (used_reg != '0)
                            begin
                                q_take   = 1'b1;
                                rem_next = REM_W'(n_pop);
                            end
                            else if (out_free)
                            begin
                                q_take = 1'b1;
                                load   = 1'b1;
                                ld_st  = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_take = 1'b1;
                                load   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_POP_RD:
            begin
                ram_re = 1'b1;
            end
            BK_POP_OUT:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    ld_byte   = ram_rdata;
                    ld_last   = (rem_reg == REM_W'(1));
                    ri_next   = (ri_reg == IDX_W'(CAPACITY - 1)) ?
                                '0 : ri_reg + IDX_W'(1);
                    used_next = used_reg - CNT_W'(1);
                    rem_next  = rem_reg - REM_W'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        // Free space after this result, masked to the field width
        free_nxt = CNT_W'(CAPACITY) - used_next;
        free_ext = FW'(free_nxt);
        ld_free  = free_ext[FREE_W-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            wi_reg    <= '0;
            ri_reg    <= '0;
            used_reg  <= '0;
            pend_reg  <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wi_reg    <= wi_next;
            ri_reg    <= ri_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            rem_reg   <= rem_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ost_reg   <= ld_st;
            obyte_reg <= ld_byte;
            olast_reg <= ld_last;
            ofree_reg <= ld_free;
        end
    end

    assign out_valid   = ov_reg;
    assign status      = ost_reg;
    assign popped_byte = obyte_reg;
    assign last        = olast_reg;
    assign free_space  = ofree_reg;

endmodule

// ===== rtl/chunked_byte_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// chunked_byte_ring_buffer_top
// Byte ring buffer with chunk reservation, byte push and bounded pop.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------
//   input   | in        | in_valid/in_ready  | operation chunk_length
//           |           |                    | data_byte pop_limit
//   result  | out       | out_valid/out_ready| status popped_byte last
//           |           |                    | free_space
//
// Reserve, push, unused codes and a pop of an empty buffer are each done as
// the back end takes them; a pop of n bytes first takes the request, then for
// each byte does the store's registered read and then the result load.
// A two-entry queue sits between the front and the back end, so transactions
// keep being taken while a result waits at the output register.
// Reset clears indices, counts and the queue; store contents stay undefined.
// ----------------------------------------------------------------------------
module chunked_byte_ring_buffer_top #(
    parameter int CAPACITY = cbrb_pkg::CAPACITY_DEF,
    parameter int MAX_POP  = cbrb_pkg::MAX_POP_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cbrb_pkg::OP_W-1:0]      operation,
    input  logic [cbrb_pkg::LEN_W-1:0]     chunk_length,
    input  logic [cbrb_pkg::DATA_W-1:0]    data_byte,
    input  logic [cbrb_pkg::LIMIT_W-1:0]   pop_limit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cbrb_pkg::STATUS_W-1:0]  status,
    output logic [cbrb_pkg::DATA_W-1:0]    popped_byte,
    output logic                           last,
    output logic [cbrb_pkg::FREE_W-1:0]    free_space
);

    import cbrb_pkg::*;

    logic   q_valid;
    item_t  q_item;
    logic   q_take;

    // Accept and classify
    cbrb_front #(
        .MAX_POP (MAX_POP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .chunk_length (chunk_length),
        .data_byte    (data_byte),
        .pop_limit    (pop_limit),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take)
    );

    // Execute against the store
    cbrb_back #(
        .CAPACITY (CAPACITY),
        .MAX_POP  (MAX_POP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .popped_byte (popped_byte),
        .last        (last),
        .free_space  (free_space)
    );

endmodule

// ===== rtl/cbrb_checker.sv =====
// ----------------------------------------------------------------------------
// cbrb_checker
// Port-level checks on the result channel of the ring buffer.
// ----------------------------------------------------------------------------
module cbrb_checker #(
    parameter int CAPACITY = cbrb_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [cbrb_pkg::STATUS_W-1:0]  status,
    input  logic [cbrb_pkg::DATA_W-1:0]    popped_byte,
    input  logic                           last,
    input  logic [cbrb_pkg::FREE_W-1:0]    free_space
);

    import cbrb_pkg::*;

    localparam bit FREE_FITS = (CAPACITY < (1 << FREE_W));

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({status, popped_byte, last, free_space}))
        else $error("result changed while stalled");

    // Non-ok results are single results that carry no byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && popped_byte == '0)
        else $error("error result not final or carries a byte");

    // Free space never exceeds capacity
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !FREE_FITS || free_space <= FREE_W'(CAPACITY))
        else $error("free space above capacity");

    // An empty answer means the whole buffer is free
    a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> !FREE_FITS
            || free_space == FREE_W'(CAPACITY))
        else $error("empty result with bytes still stored");

endmodule

bind chunked_byte_ring_buffer_top cbrb_checker #(.CAPACITY(CAPACITY)) u_cbrb_checker (.*);
